>>> design/salloc_pkg.sv
// ----------------------------------------------------------------------------
// salloc_pkg
// Shared types and constants of the stack allocator with its free table.
// ----------------------------------------------------------------------------
package salloc_pkg;

    // free table and address space
    localparam int FREE_SLOTS = 16;
    localparam int ADDR_BITS  = 16;
    localparam int SLOT_BITS  = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int CNT_BITS   = $clog2(FREE_SLOTS + 1);

    // field widths
    localparam int OFF_W  = 16;
    localparam int SIZE_W = 17;

    // largest usable arena, one bit wider than a size
    localparam logic [SIZE_W:0] ARENA_CAP = (SIZE_W + 1)'(64'd1 << ADDR_BITS);

    // reset value of the arena size register
    localparam logic [SIZE_W-1:0] ARENA_RESET = SIZE_W'(65536);

    // operation codes
    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RESIZE = 2'd2
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SEARCH,
        S_COMPACT,
        S_BUMP,
        S_FREE,
        S_DONE
    } state_t;

    // one request word
    typedef struct packed {
        op_t                op;
        logic [OFF_W-1:0]   boff;
        logic [SIZE_W-1:0]  bsize;
        logic [SIZE_W-1:0]  req;
    } item_t;

    // one result word
    typedef struct packed {
        status_t            status;
        logic [OFF_W-1:0]   off;
        logic [SIZE_W-1:0]  size;
        logic               moved;
    } res_t;

    // one free table entry
    typedef struct packed {
        logic [OFF_W-1:0]   base;
        logic [SIZE_W-1:0]  len;
    } entry_t;

    // free table access from the controller
    typedef struct packed {
        logic               we;
        logic [SLOT_BITS-1:0] waddr;
        entry_t             wdata;
        logic [SLOT_BITS-1:0] raddr;
    } ram_req_t;

endpackage

>>> design/salloc_ram.sv
// ----------------------------------------------------------------------------
// salloc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module salloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem_reg[raddr];
    end

endmodule

>>> design/salloc_ctrl.sv
// ----------------------------------------------------------------------------
// salloc_ctrl
// Allocation sequencer: decodes a request, scans the free table newest first,
// closes the gap after a taken entry, bumps or trims the top and releases.
// ----------------------------------------------------------------------------
module salloc_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request side
    input  logic                        in_valid,
    output logic                        in_ready,
    input  salloc_pkg::item_t           in_item,
    // arena limit from configuration
    input  logic [salloc_pkg::SIZE_W-1:0] arena_limit,
    // result side
    output logic                        res_valid,
    input  logic                        res_ready,
    output salloc_pkg::res_t            res,
    // free table RAM
    output salloc_pkg::ram_req_t        ram_req,
    input  salloc_pkg::entry_t          ram_rdata
);

    import salloc_pkg::*;

    state_t                 state_reg, state_next;
    item_t                  item_reg, item_next;
    logic [SIZE_W-1:0]      top_reg, top_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [SLOT_BITS-1:0]   scan_reg, scan_next;
    logic                   reloc_reg, reloc_next;
    res_t                   res_reg, res_next;

    logic [SIZE_W:0]        at_top_sum;
    logic                   at_top;
    logic [SIZE_W:0]        bump_sum;
    logic                   bump_fail;
    logic [SIZE_W:0]        resize_sum;
    logic                   resize_fail;
    logic [SLOT_BITS-1:0]   last_idx;
    logic                   table_full;
    logic                   hit;
    logic                   scan_is_last;
    logic                   next_is_last;

    // arithmetic on the request and the top
    assign at_top_sum  = {1'b0, SIZE_W'(item_reg.boff)} + {1'b0, item_reg.bsize};
    assign at_top      = (at_top_sum == {1'b0, top_reg});
    assign bump_sum    = {1'b0, top_reg} + {1'b0, item_reg.req};
    assign bump_fail   = (bump_sum > {1'b0, arena_limit});
    assign resize_sum  = {1'b0, SIZE_W'(item_reg.boff)} + {1'b0, item_reg.req};
    assign resize_fail = (resize_sum > {1'b0, arena_limit});

    // free table bookkeeping, newest entry at the highest used slot
    assign last_idx     = SLOT_BITS'(count_reg - CNT_BITS'(1));
    assign table_full   = (count_reg == CNT_BITS'(FREE_SLOTS));
    assign hit          = (ram_rdata.len >= item_reg.req);
    assign scan_is_last = (scan_reg == last_idx);
    assign next_is_last = (({1'b0, scan_reg} + (SLOT_BITS + 1)'(1)) == {1'b0, last_idx});

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        scan_reg  <= scan_next;
        reloc_reg <= reloc_next;
        res_reg   <= res_next;
    end

    // next state, table access and result
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        top_next      = top_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        reloc_next    = reloc_reg;
        res_next      = res_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = count_reg[SLOT_BITS-1:0];
        ram_req.wdata = ram_rdata;
        ram_req.raddr = scan_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    item_next  = in_item;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE: begin
                res_next        = '0;
                res_next.status = ST_OK;
                reloc_next      = 1'b0;
                state_next      = S_DONE;
                case (item_reg.op)
                    OP_ALLOC: begin
                        state_next = S_BUMP;
                    end
                    OP_FREE: begin
                        state_next = S_FREE;
                    end
                    OP_RESIZE: begin
                        if (item_reg.req == item_reg.bsize) begin
                            res_next.off  = item_reg.boff;
                            res_next.size = item_reg.bsize;
                        end else if (item_reg.req == '0) begin
                            state_next = S_FREE;
                        end else if (item_reg.bsize == '0) begin
                            state_next = S_BUMP;
                        end else if (at_top) begin
                            res_next.off = item_reg.boff;
                            if (resize_fail) begin
                                res_next.status = ST_OOM;
                                res_next.size   = item_reg.bsize;
                            end else begin
                                top_next      = resize_sum[SIZE_W-1:0];
                                res_next.size = item_reg.req;
                            end
                        end else begin
                            reloc_next = 1'b1;
                            state_next = S_BUMP;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
                // an allocation with entries in the table scans first
                if (state_next == S_BUMP && count_reg != '0) begin
                    scan_next     = last_idx;
                    ram_req.raddr = last_idx;
                    state_next    = S_SEARCH;
                end
            end

            // read data belongs to the slot in scan_reg
            S_SEARCH: begin
                if (hit) begin
                    res_next.status = ST_OK;
                    res_next.off    = ram_rdata.base;
                    res_next.size   = ram_rdata.len;
                    res_next.moved  = reloc_reg;
                    if (scan_is_last) begin
                        count_next = count_reg - CNT_BITS'(1);
                        state_next = reloc_reg ? S_FREE : S_DONE;
                    end else begin
                        ram_req.raddr = SLOT_BITS'({1'b0, scan_reg} + (SLOT_BITS + 1)'(1));
                        state_next    = S_COMPACT;
                    end
                end else if (scan_reg == '0) begin
                    state_next = S_BUMP;
                end else begin
                    scan_next     = scan_reg - SLOT_BITS'(1);
                    ram_req.raddr = scan_reg - SLOT_BITS'(1);
                end
            end

            // move the entry above the gap down by one slot
            S_COMPACT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = scan_reg;
                ram_req.wdata = ram_rdata;
                if (next_is_last) begin
                    count_next = count_reg - CNT_BITS'(1);
                    state_next = reloc_reg ? S_FREE : S_DONE;
                end else begin
                    scan_next     = SLOT_BITS'({1'b0, scan_reg} + (SLOT_BITS + 1)'(1));
                    ram_req.raddr = SLOT_BITS'({1'b0, scan_reg} + (SLOT_BITS + 1)'(2));
                end
            end

            // fresh space from the top
            S_BUMP: begin
                if (bump_fail) begin
                    res_next.status = ST_OOM;
                    res_next.moved  = 1'b0;
                    if (reloc_reg) begin
                        res_next.off  = item_reg.boff;
                        res_next.size = item_reg.bsize;
                    end else begin
                        res_next.off  = '0;
                        res_next.size = '0;
                    end
                    state_next = S_DONE;
                end else begin
                    res_next.status = ST_OK;
                    res_next.off    = top_reg[OFF_W-1:0];
                    res_next.size   = item_reg.req;
                    res_next.moved  = reloc_reg;
                    top_next        = bump_sum[SIZE_W-1:0];
                    state_next      = reloc_reg ? S_FREE : S_DONE;
                end
            end

            // release the input block
            S_FREE: begin
                res_next.status = ST_OK;
                if (item_reg.bsize == '0) begin
                    res_next.status = ST_OK;
                end else if (at_top) begin
                    top_next = top_reg - item_reg.bsize;
                end else if (table_full) begin
                    res_next.status = ST_FULL;
                end else begin
                    ram_req.we         = 1'b1;
                    ram_req.waddr      = count_reg[SLOT_BITS-1:0];
                    ram_req.wdata.base = item_reg.boff;
                    ram_req.wdata.len  = item_reg.bsize;
                    count_next         = count_reg + CNT_BITS'(1);
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/stack_allocator_with_free_list.sv
// ----------------------------------------------------------------------------
// stack_allocator_with_free_list
// Arena allocator with a bump top pointer and a first-fit table of freed
// blocks; stream request and result channels and one configuration register.
// ----------------------------------------------------------------------------
// Handles one request at a time. A trivial request (same-size resize, unknown
// operation) or an in-place resize at the top goes from the decode state
// straight to the done state; a free passes through the free state on the way.
// An allocation reads free-table entries in the newest-first search, bumps
// the top when the table is empty or nothing fits, and shifts entries down to
// close the gap after a taken entry; a relocating resize then releases the old
// block in the free state. The search reads one entry per cycle and the shifts
// go entry by entry, since the free-table RAM has a single read port. A
// finished result waits in the output register while the next request is
// taken. No clearing pass is needed after reset.
module stack_allocator_with_free_list (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // block_offset[15:0], block_size[32:16],
                                    // request_size[49:33], zero fill
    input  logic [1:0]  s_tuser,    // operation[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // result_offset[15:0], result_size[32:16],
                                    // zero fill
    output logic [2:0]  m_tuser,    // status[1:0], moved[2]
    // configuration: arena_size
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    import salloc_pkg::*;

    logic [SIZE_W-1:0]  arena_size_reg;
    logic [SIZE_W-1:0]  arena_limit;
    item_t              in_item;
    logic               res_valid;
    logic               res_ready;
    res_t               res;
    ram_req_t           ram_req;
    entry_t             ram_rdata;
    logic               m_tvalid_reg;
    res_t               m_res_reg;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arena_size_reg <= ARENA_RESET;
        end else if (cfg_valid && cfg_ready) begin
            arena_size_reg <= cfg_data;
        end
    end

    // usable arena limit
    assign arena_limit = ({1'b0, arena_size_reg} > ARENA_CAP) ?
                         ARENA_CAP[SIZE_W-1:0] : arena_size_reg;

    // request word unpacking
    assign in_item.op    = op_t'(s_tuser);
    assign in_item.boff  = s_tdata[15:0];
    assign in_item.bsize = s_tdata[32:16];
    assign in_item.req   = s_tdata[49:33];

    salloc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (in_item),
        .arena_limit (arena_limit),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    salloc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (FREE_SLOTS)
    ) u_free_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_res_reg.size, m_res_reg.off};
    assign m_tuser  = {m_res_reg.moved, m_res_reg.status};

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    // a new output word always comes from a finished request
    a_out_from_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(res_valid))
        else $error("output word without a finished request");

    // a relocated block is never reported out of memory
    a_no_moved_oom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[2] && (m_tuser[1:0] == ST_OOM)))
        else $error("moved flag set on an out-of-memory result");

    // the controller holds its result until the output register takes it
    a_res_held: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("finished result changed before hand-off");

endmodule
